/* rtl/sha256c_pkg.sv */
// ----------------------------------------------------------------------------
// sha256c_pkg
// Shared types, round constants and round functions for the SHA-256
// compression rounds unit.
// ----------------------------------------------------------------------------
package sha256c_pkg;

  localparam int NumWords  = 8;
  localparam int NumRounds = 64;
  localparam int WordW     = 32;
  localparam int IdxW      = $clog2(NumWords);
  localparam int RoundW    = $clog2(NumRounds);

  typedef logic [WordW-1:0] word_t;
  typedef logic [NumWords-1:0][WordW-1:0] vars_t;
  typedef logic [RoundW-1:0] round_t;
  typedef logic [IdxW-1:0] idx_t;

  typedef enum logic {
    ACT_LOAD  = 1'b0,
    ACT_ROUND = 1'b1
  } action_t;

  localparam round_t LastRound = round_t'(NumRounds - 1);
  localparam idx_t   LastIdx   = idx_t'(NumWords - 1);

  // input word
  typedef struct packed {
    logic  action;
    idx_t  hash_index;
    word_t word_value;
  } item_t;

  // result word
  typedef struct packed {
    idx_t  out_index;
    word_t out_value;
    logic  last;
  } result_t;

  // round constant table
  function automatic word_t kconst(input round_t t);
    word_t k;
    case (t)
      6'd0:  k = 32'h428a2f98;  6'd1:  k = 32'h71374491;
      6'd2:  k = 32'hb5c0fbcf;  6'd3:  k = 32'he9b5dba5;
      6'd4:  k = 32'h3956c25b;  6'd5:  k = 32'h59f111f1;
      6'd6:  k = 32'h923f82a4;  6'd7:  k = 32'hab1c5ed5;
      6'd8:  k = 32'hd807aa98;  6'd9:  k = 32'h12835b01;
      6'd10: k = 32'h243185be;  6'd11: k = 32'h550c7dc3;
      6'd12: k = 32'h72be5d74;  6'd13: k = 32'h80deb1fe;
      6'd14: k = 32'h9bdc06a7;  6'd15: k = 32'hc19bf174;
      6'd16: k = 32'he49b69c1;  6'd17: k = 32'hefbe4786;
      6'd18: k = 32'h0fc19dc6;  6'd19: k = 32'h240ca1cc;
      6'd20: k = 32'h2de92c6f;  6'd21: k = 32'h4a7484aa;
      6'd22: k = 32'h5cb0a9dc;  6'd23: k = 32'h76f988da;
      6'd24: k = 32'h983e5152;  6'd25: k = 32'ha831c66d;
      6'd26: k = 32'hb00327c8;  6'd27: k = 32'hbf597fc7;
      6'd28: k = 32'hc6e00bf3;  6'd29: k = 32'hd5a79147;
      6'd30: k = 32'h06ca6351;  6'd31: k = 32'h14292967;
      6'd32: k = 32'h27b70a85;  6'd33: k = 32'h2e1b2138;
      6'd34: k = 32'h4d2c6dfc;  6'd35: k = 32'h53380d13;
      6'd36: k = 32'h650a7354;  6'd37: k = 32'h766a0abb;
      6'd38: k = 32'h81c2c92e;  6'd39: k = 32'h92722c85;
      6'd40: k = 32'ha2bfe8a1;  6'd41: k = 32'ha81a664b;
      6'd42: k = 32'hc24b8b70;  6'd43: k = 32'hc76c51a3;
      6'd44: k = 32'hd192e819;  6'd45: k = 32'hd6990624;
      6'd46: k = 32'hf40e3585;  6'd47: k = 32'h106aa070;
      6'd48: k = 32'h19a4c116;  6'd49: k = 32'h1e376c08;
      6'd50: k = 32'h2748774c;  6'd51: k = 32'h34b0bcb5;
      6'd52: k = 32'h391c0cb3;  6'd53: k = 32'h4ed8aa4a;
      6'd54: k = 32'h5b9cca4f;  6'd55: k = 32'h682e6ff3;
      6'd56: k = 32'h748f82ee;  6'd57: k = 32'h78a5636f;
      6'd58: k = 32'h84c87814;  6'd59: k = 32'h8cc70208;
      6'd60: k = 32'h90befffa;  6'd61: k = 32'ha4506ceb;
      6'd62: k = 32'hbef9a3f7;  6'd63: k = 32'hc67178f2;
      default: k = '0;
    endcase
    return k;
  endfunction

  // upper-case sigma functions
  function automatic word_t big_sigma0(input word_t x);
    return {x[1:0], x[31:2]} ^ {x[12:0], x[31:13]} ^ {x[21:0], x[31:22]};
  endfunction

  function automatic word_t big_sigma1(input word_t x);
    return {x[5:0], x[31:6]} ^ {x[10:0], x[31:11]} ^ {x[24:0], x[31:25]};
  endfunction

endpackage

/* rtl/sha256c_round.sv */
// ----------------------------------------------------------------------------
// sha256c_round
// One SHA-256 round on the working variables, plus the end-of-block sum into
// the chaining hash words.
// ----------------------------------------------------------------------------
module sha256c_round (
  input  sha256c_pkg::vars_t  hash,
  input  sha256c_pkg::vars_t  work,
  input  sha256c_pkg::round_t round,
  input  sha256c_pkg::word_t  w,
  output sha256c_pkg::vars_t  work_next,
  output sha256c_pkg::vars_t  hash_sum
);
  import sha256c_pkg::*;

  vars_t src;
  word_t s0, s1, ch, mj, t1, t2;

  // round zero starts from the chaining words
  assign src = (round == '0) ? hash : work;

  // round function
  always_comb begin
    s1 = big_sigma1(src[4]);
    ch = (src[4] & src[5]) ^ (~src[4] & src[6]);
    s0 = big_sigma0(src[0]);
    mj = (src[0] & src[1]) ^ (src[0] & src[2]) ^ (src[1] & src[2]);
    t1 = src[7] + s1 + ch + kconst(round) + w;
    t2 = s0 + mj;
    work_next[7] = src[6];
    work_next[6] = src[5];
    work_next[5] = src[4];
    work_next[4] = src[3] + t1;
    work_next[3] = src[2];
    work_next[2] = src[1];
    work_next[1] = src[0];
    work_next[0] = t1 + t2;
  end

  // chaining sum after the last round
  always_comb begin
    for (int i = 0; i < NumWords; i++) begin
      hash_sum[i] = hash[i] + work_next[i];
    end
  end

endmodule

/* rtl/sha256c_outbuf.sv */
// ----------------------------------------------------------------------------
// sha256c_outbuf
// Holds the eight updated hash words of a finished block and sends them out
// one word per handshake, in index order.
// ----------------------------------------------------------------------------
module sha256c_outbuf (
  input  logic                clk,
  input  logic                rst,
  input  logic                capture,
  input  sha256c_pkg::vars_t  words,
  output logic                busy,
  output logic                result_valid,
  input  logic                result_stall,
  output sha256c_pkg::result_t result
);
  import sha256c_pkg::*;

  vars_t buffer;
  idx_t  count;
  logic  pop;

  assign pop          = busy && !result_stall;
  assign result_valid = busy;

  // result word from the head of the shift line
  always_comb begin
    result.out_index = count;
    result.out_value = buffer[0];
    result.last      = (count == LastIdx);
  end

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      count <= '0;
    end else if (capture) begin
      busy  <= 1'b1;
      count <= '0;
    end else if (pop) begin
      count <= count + 1'b1;
      if (count == LastIdx) begin
        busy <= 1'b0;
      end
    end
  end

  // shift line of words
  always_ff @(posedge clk) begin
    if (capture) begin
      buffer <= words;
    end else if (pop) begin
      for (int i = 0; i < NumWords - 1; i++) begin
        buffer[i] <= buffer[i+1];
      end
    end
  end

endmodule

/* rtl/sha256_compression_rounds_unit.sv */
// ----------------------------------------------------------------------------
// sha256_compression_rounds_unit
// SHA-256 compression, one round per schedule word, with chaining hash words
// loaded one at a time and the updated words sent out after the last round.
// ----------------------------------------------------------------------------
// Throughput: one word per unstalled cycle; each round is done in the cycle
//   its word is accepted, by the round logic between the state registers.
// Latency: the eight result words start the cycle after round 63 is accepted
//   and leave one per unstalled cycle; a block finishing while the previous
//   results are still held stalls the input until they have drained.
// Reset: clears the round count and the result buffer's busy flag and word
//   count; hash words are undefined until loaded.
module sha256_compression_rounds_unit (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  sha256c_pkg::item_t   item,
  output logic                 result_valid,
  input  logic                 result_stall,
  output sha256c_pkg::result_t result
);
  import sha256c_pkg::*;

  vars_t  hash;
  vars_t  work;
  round_t round;
  vars_t  work_next;
  vars_t  hash_sum;
  logic   accept;
  logic   is_round;
  logic   finish;
  logic   busy;

  // input handshake
  assign item_stall = busy && (round == LastRound);
  assign accept     = item_valid && !item_stall;
  assign is_round   = (action_t'(item.action) == ACT_ROUND);
  assign finish     = accept && is_round && (round == LastRound);

  sha256c_round u_round (
    .hash      (hash),
    .work      (work),
    .round     (round),
    .w         (item.word_value),
    .work_next (work_next),
    .hash_sum  (hash_sum)
  );

  // round count
  always_ff @(posedge clk) begin
    if (rst) begin
      round <= '0;
    end else if (accept) begin
      if (is_round) begin
        round <= round + 1'b1;
      end else begin
        round <= '0;
      end
    end
  end

  // working variables and chaining words
  always_ff @(posedge clk) begin
    if (accept) begin
      if (is_round) begin
        work <= work_next;
        if (round == LastRound) begin
          hash <= hash_sum;
        end
      end else begin
        hash[item.hash_index] <= item.word_value;
      end
    end
  end

  sha256c_outbuf u_outbuf (
    .clk          (clk),
    .rst          (rst),
    .capture      (finish),
    .words        (hash_sum),
    .busy         (busy),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
